// File: sv/u8u16_pkg.sv
`default_nettype none

package u8u16_pkg;

    localparam logic [1:0] KIND_UNIT   = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ORDER_BIG = 2'd2;

    localparam logic REG_BYTE_ORDER = 1'b0;
    localparam logic REG_MAX_UNITS  = 1'b1;

    localparam logic [15:0] MAX_UNITS_RESET = 16'd255;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h010000;
    localparam logic [CP_W-1:0] CP_LOW_2     = 21'h000080;
    localparam logic [CP_W-1:0] CP_LOW_3     = 21'h000800;
    localparam logic [CP_W-1:0] SURR_MASK    = 21'h1FF800;
    localparam logic [CP_W-1:0] SURR_BASE    = 21'h00D800;

    localparam logic [15:0] HI_SURR  = 16'hD800;
    localparam logic [15:0] LO_SURR  = 16'hDC00;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  result_kind;
        logic [15:0] unit_count;
    } result_t;

    typedef struct packed {
        logic [1:0]        n;
        result_t [2:0]     slot;
    } bundle_t;

    typedef struct packed {
        logic [1:0]  byte_order;
        logic [15:0] max_units;
    } cfg_t;

    function automatic logic [15:0] order_unit(input logic [15:0] u, input logic [1:0] ord);
        return (ord == ORDER_BIG) ? {u[7:0], u[15:8]} : u;
    endfunction

endpackage

`default_nettype wire

// File: sv/u8u16_dec.sv
`default_nettype none

module u8u16_dec #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                take,
    input  wire logic [7:0]          byte_in,
    input  wire logic                final_byte,
    input  wire u8u16_pkg::cfg_t     cfg,
    output u8u16_pkg::bundle_t       bundle
);
    import u8u16_pkg::*;

    localparam int LIM_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [CP_W-1:0]        acc_reg, acc_next;
    logic [2:0]             br_reg, br_next;
    logic [2:0]             seq_reg, seq_next;
    logic [COUNT_WIDTH-1:0] units_reg, units_next;
    logic                   stop_reg, stop_next;

    logic [LIM_W-1:0] cap, max_ext, limit;

    assign cap     = LIM_W'({COUNT_WIDTH{1'b1}});
    assign max_ext = LIM_W'(cfg.max_units);
    assign limit   = (max_ext < cap) ? max_ext : cap;

    always_comb begin
        logic                   emit_go;
        logic [CP_W-1:0]        cp;
        logic [CP_W-1:0]        lowest;
        logic [CP_W-1:0]        v;
        logic [1:0]             need;
        logic [LIM_W:0]         units_sum;
        logic [COUNT_WIDTH-1:0] units_after;
        logic [1:0]             nu;
        logic [15:0]            u0, u1;
        logic                   term_fin, term_err;
        result_t                r_u0, r_u1, r_t;

        acc_next    = acc_reg;
        br_next     = br_reg;
        seq_next    = seq_reg;
        stop_next   = stop_reg;
        emit_go     = 1'b0;
        cp          = '0;
        lowest      = CP_SUPP_BASE;
        term_fin    = 1'b0;
        term_err    = 1'b0;
        nu          = 2'd0;
        u0          = '0;
        u1          = '0;
        units_after = units_reg;

        if (!stop_reg) begin
            if (br_reg == 3'd0) begin
                if (LIM_W'(units_reg) >= limit) begin
                    term_fin = 1'b1;
                end else if (byte_in == 8'd0) begin
                    term_fin = 1'b1;
                end else if (!byte_in[7]) begin
                    emit_go = 1'b1;
                    cp      = CP_W'(byte_in);
                end else begin
                    priority if (byte_in[7:5] == 3'b110) begin
                        acc_next = CP_W'(byte_in[4:0]);
                        seq_next = 3'd2;
                    end else if (byte_in[7:4] == 4'b1110) begin
                        acc_next = CP_W'(byte_in[3:0]);
                        seq_next = 3'd3;
                    end else if (byte_in[7:3] == 5'b11110) begin
                        acc_next = CP_W'(byte_in[2:0]);
                        seq_next = 3'd4;
                    end else begin
                        seq_next = 3'd0;
                    end
                    if (seq_next == 3'd0 || final_byte) begin
                        term_err = 1'b1;
                    end else begin
                        br_next = seq_next - 3'd1;
                    end
                end
            end else begin
                if (byte_in[7:6] != 2'b10) begin
                    term_err = 1'b1;
                end else begin
                    acc_next = {acc_reg[CP_W-7:0], byte_in[5:0]};
                    br_next  = br_reg - 3'd1;
                    if (br_next == 3'd0) begin
                        priority if (seq_reg == 3'd2) begin
                            lowest = CP_LOW_2;
                        end else if (seq_reg == 3'd3) begin
                            lowest = CP_LOW_3;
                        end else begin
                            lowest = CP_SUPP_BASE;
                        end
                        if (acc_next < lowest || acc_next > CP_MAX
                            || (acc_next & SURR_MASK) == SURR_BASE) begin
                            term_err = 1'b1;
                        end else begin
                            emit_go = 1'b1;
                            cp      = acc_next;
                        end
                    end else if (final_byte) begin
                        term_err = 1'b1;
                    end
                end
            end
        end

        need      = (cp >= CP_SUPP_BASE) ? 2'd2 : 2'd1;
        units_sum = (LIM_W+1)'(units_reg) + (LIM_W+1)'(need);
        v         = cp - CP_SUPP_BASE;

        if (emit_go) begin
            if (units_sum > {1'b0, limit}) begin
                term_fin = 1'b1;
            end else begin
                nu          = need;
                units_after = units_reg + COUNT_WIDTH'(need);
                if (need == 2'd2) begin
                    u0 = HI_SURR | 16'(v[19:10]);
                    u1 = LO_SURR | 16'(v[9:0]);
                end else begin
                    u0 = cp[15:0];
                end
                if (LIM_W'(units_after) >= limit) begin
                    term_fin = 1'b1;
                end
            end
        end

        if (final_byte && !stop_reg && !term_fin && !term_err) begin
            term_fin = 1'b1;
        end

        if (term_fin || term_err) begin
            stop_next = 1'b1;
            br_next   = 3'd0;
        end
        units_next = units_after;

        if (final_byte) begin
            acc_next   = '0;
            br_next    = 3'd0;
            seq_next   = 3'd0;
            units_next = '0;
            stop_next  = 1'b0;
        end

        r_u0 = '{code_unit: order_unit(u0, cfg.byte_order), result_kind: KIND_UNIT,
                 unit_count: 16'd0};
        r_u1 = '{code_unit: order_unit(u1, cfg.byte_order), result_kind: KIND_UNIT,
                 unit_count: 16'd0};
        r_t  = '{code_unit: 16'd0, result_kind: term_err ? KIND_ERROR : KIND_FINISH,
                 unit_count: term_fin ? 16'(units_after) : 16'd0};

        bundle.slot = '0;
        unique case (nu)
            2'd0: begin
                bundle.slot[0] = r_t;
            end
            2'd1: begin
                bundle.slot[0] = r_u0;
                bundle.slot[1] = r_t;
            end
            default: begin
                bundle.slot[0] = r_u0;
                bundle.slot[1] = r_u1;
                bundle.slot[2] = r_t;
            end
        endcase
        bundle.n = nu + 2'((term_fin || term_err) ? 1 : 0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            br_reg    <= '0;
            seq_reg   <= '0;
            units_reg <= '0;
            stop_reg  <= 1'b0;
        end else if (take) begin
            acc_reg   <= acc_next;
            br_reg    <= br_next;
            seq_reg   <= seq_next;
            units_reg <= units_next;
            stop_reg  <= stop_next;
        end
    end

    a_stop_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        stop_reg |-> br_reg == 3'd0)
        else $error("stopped with sequence bytes pending");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && final_byte |=> !stop_reg && units_reg == '0 && br_reg == 3'd0)
        else $error("string state not cleared after final byte");

    a_units_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !final_byte && $stable(cfg.max_units) |=> LIM_W'(units_reg) <= limit)
        else $error("unit count beyond limit");

endmodule

`default_nettype wire

// File: sv/u8u16_obuf.sv
`default_nettype none

module u8u16_obuf (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire u8u16_pkg::bundle_t  bundle,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output u8u16_pkg::result_t       m_res,
    output logic                     m_last
);
    import u8u16_pkg::*;

    result_t [2:0] slot_reg;
    logic [1:0]    cnt_reg;
    logic          load;
    logic          pop;

    assign s_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign load     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_res    = slot_reg[0];
    assign m_last   = (cnt_reg == 2'd1);

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= bundle.slot;
        end else if (pop) begin
            slot_reg <= {slot_reg[2], slot_reg[2:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= bundle.n;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load && bundle.n != 2'd0 |=> m_tvalid && m_res == $past(bundle.slot[0]))
        else $error("loaded result not presented");

    a_units_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg > 2'd1 |-> slot_reg[0].result_kind == KIND_UNIT)
        else $error("terminal result ahead of other results");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg > 2'd1 |-> !s_tready)
        else $error("input taken while results remain");

endmodule

`default_nettype wire

// File: sv/utf8_to_utf16_stream_core.sv
// Results: first result of a byte is valid in the cycle after its input transfer.
// Throughput: one byte per cycle while each byte gives at most one result and the
//   output accepts it; a byte giving k results (k up to 3) holds the input until
//   the result buffer has drained to its last result and that result is taken.
// Reset: synchronous, active low; clears string state and buffer, byte_order to
//   host order and max_units to 255.
`default_nettype none

module utf8_to_utf16_stream_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] code_unit, [31:16] unit_count
    output logic [1:0]       m_tuser,   // [1:0] result_kind
    output logic             m_tlast
);
    import u8u16_pkg::*;

    cfg_t    cfg_reg;
    bundle_t bundle;
    result_t m_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.byte_order <= 2'd0;
            cfg_reg.max_units  <= MAX_UNITS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_BYTE_ORDER: cfg_reg.byte_order <= cfg_wdata[1:0];
                REG_MAX_UNITS:  cfg_reg.max_units  <= cfg_wdata;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    u8u16_dec #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (s_tvalid && s_tready),
        .byte_in    (s_tdata),
        .final_byte (s_tlast),
        .cfg        (cfg_reg),
        .bundle     (bundle)
    );

    u8u16_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .bundle   (bundle),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res),
        .m_last   (m_tlast)
    );

    assign m_tdata = {m_res.unit_count, m_res.code_unit};
    assign m_tuser = m_res.result_kind;

endmodule

`default_nettype wire

// File: dv/tb_utf8_to_utf16_stream_core.sv
`timescale 1ns / 100ps

module tb_utf8_to_utf16_stream_core;

    import u8u16_pkg::*;

    typedef struct packed {
        logic [15:0] code;
        logic [1:0]  kind;
        logic [15:0] count;
        logic        last;
    } utf16_xfer_t;

    class utf16_tracker;
        logic [1:0]  byte_order;
        logic [15:0] max_units;
        logic [31:0] acc;
        logic [2:0]  remaining;
        logic [2:0]  seq_len;
        logic [15:0] units;
        logic        halted;

        utf16_xfer_t units_due[$];
        utf16_xfer_t byte_results[3];
        int          n_byte_results;

        int errors;
        int n_unit;
        int n_finish;
        int n_invalid;

        function new();
            byte_order = 2'd0;
            max_units  = MAX_UNITS_RESET;
            acc        = '0;
            remaining  = '0;
            seq_len    = '0;
            units      = '0;
            halted     = 1'b0;
            errors     = 0;
            n_unit     = 0;
            n_finish   = 0;
            n_invalid  = 0;
        endfunction

        function int pending();
            return units_due.size();
        endfunction

        function void write_reg(logic addr, logic [15:0] data);
            if (addr == REG_BYTE_ORDER) begin
                byte_order = data[1:0];
            end else begin
                max_units = data;
            end
        endfunction

        function void add_result(logic [15:0] code, logic [1:0] kind, logic [15:0] count);
            byte_results[n_byte_results] = '{code, kind, count, 1'b0};
            n_byte_results++;
        endfunction

        function void finish_string();
            add_result(16'h0000, KIND_FINISH, units);
            halted    = 1'b1;
            remaining = '0;
        endfunction

        function void reject_sequence();
            add_result(16'h0000, KIND_ERROR, 16'h0000);
            halted    = 1'b1;
            remaining = '0;
        endfunction

        function void put_unit(logic [15:0] u);
            logic [15:0] ordered;
            ordered = (byte_order == ORDER_BIG) ? {u[7:0], u[15:8]} : u;
            add_result(ordered, KIND_UNIT, 16'h0000);
            units++;
        endfunction

        function void put_code_point(logic [31:0] cp);
            int          need;
            int          cnt;
            int          lim;
            logic [31:0] v;
            need = (cp >= CP_SUPP_BASE) ? 2 : 1;
            cnt  = units;
            lim  = max_units;
            if (cnt + need > lim) begin
                finish_string();
                return;
            end
            if (need == 2) begin
                v = cp - CP_SUPP_BASE;
                put_unit(HI_SURR | {6'b0, v[19:10]});
                put_unit(LO_SURR | {6'b0, v[9:0]});
            end else begin
                put_unit(cp[15:0]);
            end
            if (units >= max_units) begin
                finish_string();
            end
        endfunction

        function void close_sequence();
            logic [31:0] lowest;
            lowest = (seq_len == 3'd2) ? CP_LOW_2 : (seq_len == 3'd3) ? CP_LOW_3 : CP_SUPP_BASE;
            if (acc < lowest || acc > CP_MAX || (acc & SURR_MASK) == SURR_BASE) begin
                reject_sequence();
            end else begin
                put_code_point(acc);
            end
        endfunction

        function void take_byte(logic [7:0] b, logic fin);
            utf16_xfer_t x;
            n_byte_results = 0;
            if (!halted) begin
                if (remaining == 3'd0) begin
                    if (units >= max_units) begin
                        finish_string();
                    end else if (b == 8'h00) begin
                        finish_string();
                    end else if (b < 8'h80) begin
                        put_code_point({24'b0, b});
                    end else begin
                        if (b[7:5] == 3'b110) begin
                            acc     = {27'b0, b[4:0]};
                            seq_len = 3'd2;
                        end else if (b[7:4] == 4'b1110) begin
                            acc     = {28'b0, b[3:0]};
                            seq_len = 3'd3;
                        end else if (b[7:3] == 5'b11110) begin
                            acc     = {29'b0, b[2:0]};
                            seq_len = 3'd4;
                        end else begin
                            seq_len = 3'd0;
                        end
                        if (seq_len == 3'd0 || fin) begin
                            reject_sequence();
                        end else begin
                            remaining = seq_len - 3'd1;
                        end
                    end
                end else begin
                    if (b[7:6] != 2'b10) begin
                        reject_sequence();
                    end else begin
                        acc = {acc[25:0], b[5:0]};
                        remaining--;
                        if (remaining == 3'd0) begin
                            close_sequence();
                        end else if (fin) begin
                            reject_sequence();
                        end
                    end
                end
                if (fin && !halted) begin
                    finish_string();
                end
            end
            if (fin) begin
                acc       = '0;
                remaining = '0;
                seq_len   = '0;
                units     = '0;
                halted    = 1'b0;
            end
            for (int i = 0; i < n_byte_results; i++) begin
                x      = byte_results[i];
                x.last = (i == n_byte_results - 1);
                units_due.push_back(x);
            end
        endfunction

        function void match_result(logic [31:0] tdata, logic [1:0] tuser, logic tlast);
            utf16_xfer_t want;
            if (units_due.size() == 0) begin
                $display("%0t: unexpected transfer: unit %h kind %0d count %0d last %0b",
                         $time, tdata[15:0], tuser, tdata[31:16], tlast);
                errors++;
                return;
            end
            want = units_due.pop_front();
            case (want.kind)
                KIND_UNIT:   n_unit++;
                KIND_FINISH: n_finish++;
                default:     n_invalid++;
            endcase
            if (tdata[15:0] !== want.code) begin
                $display("%0t: code_unit expected %h actual %h", $time, want.code, tdata[15:0]);
                errors++;
            end
            if (tuser !== want.kind) begin
                $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, tuser);
                errors++;
            end
            if (tdata[31:16] !== want.count) begin
                $display("%0t: unit_count expected %0d actual %0d", $time, want.count,
                         tdata[31:16]);
                errors++;
            end
            if (tlast !== want.last) begin
                $display("%0t: end_of_run expected %0b actual %0b", $time, want.last, tlast);
                errors++;
            end
        endfunction
    endclass

    localparam logic [1:0] ORDER_HOST   = 2'd0;
    localparam logic [1:0] ORDER_LITTLE = 2'd1;
    localparam logic [1:0] ORDER_SPARE  = 2'd3;

    localparam int IDLE_LIMIT     = 2000;
    localparam int LATENCY_PAD    = 4;
    localparam int N_PHASES       = 6;
    localparam int BYTES_PER_PHASE = 32;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    utf16_tracker trk;
    logic [7:0]   str_bytes[$];
    logic         tx_idle = 1'b1;
    logic         rx_idle = 1'b1;
    int           idle_cycles = 0;
    int           bytes_sent = 0;
    int           strings_sent = 0;
    int           settings_used = 0;

    utf8_to_utf16_stream_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                trk.match_result(m_tdata, m_tuser, m_tlast);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_utf8_to_utf16_stream_core NOT OK");
        $finish;
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (stall == 0 && rx_idle && $urandom_range(0, 3) == 0) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task send_byte(logic [7:0] b, logic fin);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        trk.take_byte(b, fin);
        bytes_sent++;
    endtask

    task send_string();
        for (int i = 0; i < str_bytes.size(); i++) begin
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
        end
        str_bytes.delete();
        strings_sent++;
    endtask

    task drain_results();
        s_tvalid <= 1'b0;
        while (trk.pending() != 0) @(posedge aclk);
        repeat (LATENCY_PAD) @(posedge aclk);
    endtask

    task set_config(logic [1:0] order, logic [15:0] limit);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_BYTE_ORDER;
        cfg_wdata <= {14'b0, order};
        @(posedge aclk);
        trk.write_reg(REG_BYTE_ORDER, {14'b0, order});
        cfg_addr  <= REG_MAX_UNITS;
        cfg_wdata <= limit;
        @(posedge aclk);
        trk.write_reg(REG_MAX_UNITS, limit);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    task push_cp(logic [20:0] cp);
        if (cp < 21'h80) begin
            str_bytes.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            str_bytes.push_back({3'b110, cp[10:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            str_bytes.push_back({4'b1110, cp[15:12]});
            str_bytes.push_back({2'b10, cp[11:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            str_bytes.push_back({5'b11110, cp[20:18]});
            str_bytes.push_back({2'b10, cp[17:12]});
            str_bytes.push_back({2'b10, cp[11:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    task push_random_char();
        logic [20:0] cp;
        case ($urandom_range(0, 3))
            0: cp = 21'($urandom_range(1, 'h7F));
            1: cp = 21'($urandom_range('h80, 'h7FF));
            2: begin
                cp = 21'($urandom_range('h800, 'hF7FF));
                if (cp >= 21'hD800) cp = cp + 21'h800;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        push_cp(cp);
    endtask

    task push_lead(int len);
        case (len)
            2:       str_bytes.push_back(8'($urandom_range('hC2, 'hDF)));
            3:       str_bytes.push_back(8'($urandom_range('hE1, 'hEC)));
            default: str_bytes.push_back(8'($urandom_range('hF1, 'hF3)));
        endcase
    endtask

    task push_defect();
        int len;
        int r;
        case ($urandom_range(0, 7))
            0: repeat ($urandom_range(1, 3)) str_bytes.push_back(8'($urandom_range(0, 255)));
            1: begin
                case ($urandom_range(0, 2))
                    0: begin
                        str_bytes.push_back(8'($urandom_range('hC0, 'hC1)));
                        str_bytes.push_back(cont_byte());
                    end
                    1: begin
                        str_bytes.push_back(8'hE0);
                        str_bytes.push_back(8'($urandom_range('h80, 'h9F)));
                        str_bytes.push_back(cont_byte());
                    end
                    default: begin
                        str_bytes.push_back(8'hF0);
                        str_bytes.push_back(8'($urandom_range('h80, 'h8F)));
                        str_bytes.push_back(cont_byte());
                        str_bytes.push_back(cont_byte());
                    end
                endcase
            end
            2: begin
                str_bytes.push_back(8'hED);
                str_bytes.push_back(8'($urandom_range('hA0, 'hBF)));
                str_bytes.push_back(cont_byte());
            end
            3: begin
                if ($urandom_range(0, 1) == 0) begin
                    str_bytes.push_back(8'hF4);
                    str_bytes.push_back(8'($urandom_range('h90, 'hBF)));
                end else begin
                    str_bytes.push_back(8'($urandom_range('hF5, 'hF7)));
                    str_bytes.push_back(cont_byte());
                end
                str_bytes.push_back(cont_byte());
                str_bytes.push_back(cont_byte());
            end
            4: begin
                len = $urandom_range(2, 4);
                push_lead(len);
                repeat ($urandom_range(0, len - 2)) str_bytes.push_back(cont_byte());
                r = $urandom_range(0, 191);
                str_bytes.push_back(8'((r < 128) ? r : r + 64));
            end
            5: begin
                str_bytes.push_back(8'($urandom_range('hF8, 'hFD)));
                str_bytes.push_back(cont_byte());
                str_bytes.push_back(cont_byte());
            end
            6: begin
                if ($urandom_range(0, 1) == 0) begin
                    str_bytes.push_back(8'($urandom_range('h80, 'hBF)));
                end else begin
                    str_bytes.push_back(8'($urandom_range('hFE, 'hFF)));
                end
            end
            default: str_bytes.push_back(8'h00);
        endcase
        repeat ($urandom_range(0, 3)) str_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task build_random_string();
        int sel;
        int len;
        sel = $urandom_range(0, 9);
        repeat ($urandom_range((sel < 7) ? 1 : 0, 8)) push_random_char();
        if (sel < 7) begin
            if ($urandom_range(0, 9) == 0) begin
                str_bytes.push_back(8'h00);
                repeat ($urandom_range(0, 2)) push_random_char();
            end
        end else if (sel < 9) begin
            push_defect();
        end else begin
            len = $urandom_range(2, 4);
            push_lead(len);
            repeat ($urandom_range(0, len - 2)) str_bytes.push_back(cont_byte());
        end
    endtask

    initial begin
        logic [1:0]  order_tab[N_PHASES];
        logic [15:0] limit_tab[N_PHASES];
        int          sent_in_phase;

        trk = new();
        order_tab = '{ORDER_BIG, ORDER_LITTLE, ORDER_SPARE, ORDER_BIG, ORDER_HOST, ORDER_LITTLE};
        limit_tab = '{16'hFFFF, 16'($urandom_range(3, 12)), 16'h0000, 16'h0001,
                      16'($urandom_range(0, 65535)), MAX_UNITS_RESET};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // range edges of the one-, two- and four-byte lengths, with a pair at the top of the space
        str_bytes = '{8'h7F, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        // NUL stops, the rest of the string is dropped
        str_bytes = '{8'h00, 8'h41};
        send_string();
        str_bytes = '{8'hC1, 8'hBF};
        send_string();
        str_bytes = '{8'hED, 8'hA0, 8'h80};
        send_string();
        str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_string();
        str_bytes = '{8'hE2, 8'h41};
        send_string();
        str_bytes = '{8'hFF};
        send_string();
        str_bytes = '{8'hE2, 8'h82};
        send_string();
        set_config(ORDER_HOST, 16'd1);
        str_bytes = '{8'h41, 8'h42};
        send_string();
        set_config(ORDER_HOST, 16'd2);
        str_bytes = '{8'h41, 8'hF0, 8'h90, 8'h80, 8'h80};
        send_string();

        for (int p = 0; p < N_PHASES; p++) begin
            set_config(order_tab[p], limit_tab[p]);
            tx_idle = (p % 3 != 2);
            rx_idle = (p % 3 != 2);
            sent_in_phase = 0;
            while (sent_in_phase < BYTES_PER_PHASE) begin
                build_random_string();
                sent_in_phase += str_bytes.size();
                send_string();
                if ($urandom_range(0, 7) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        $display("Ran %0d strings (%0d bytes) under %0d register settings, byte order codes 0-3.",
                 strings_sent, bytes_sent, settings_used + 1);
        $display("Matched %0d code units, %0d finished and %0d invalid results.",
                 trk.n_unit, trk.n_finish, trk.n_invalid);
        if (trk.errors == 0 && trk.pending() == 0) begin
            $display("tb_utf8_to_utf16_stream_core OK");
        end else begin
            $display("%0d mismatches, %0d predicted results never arrived",
                     trk.errors, trk.pending());
            $display("tb_utf8_to_utf16_stream_core NOT OK");
        end
        $finish;
    end

endmodule
